// File: rtl/bitmap_id_allocator_macros.svh
// Assertion shorthands for the identifier allocator. Both assume a clock named clk and an
// active-low asynchronous reset named arst_n in the including scope.
`ifndef BITMAP_ID_ALLOCATOR_MACROS_SVH
`define BITMAP_ID_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BIA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BIA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/bia_pkg.sv
package bia_pkg;

	localparam int NUM_WORDS = 8;
	localparam int WORD_BITS = 32;
	localparam int ID_W      = 8;
	localparam int STATUS_W  = 2;
	localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int BIT_W     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam int GID_W     = $clog2(NUM_WORDS * WORD_BITS) + 1;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [STATUS_W-1:0]  status_t;

	localparam status_t STATUS_OK        = 2'd0;
	localparam status_t STATUS_FULL      = 2'd1;
	localparam status_t STATUS_NOT_ALLOC = 2'd2;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(NUM_WORDS - 1);

	typedef struct packed {
		logic    load;
		logic    step;
		logic    set_bit;
		logic    clr_bit;
		logic    out_load;
		logic    out_grant;
		status_t out_status;
	} cmd_t;

	typedef struct packed {
		logic req_mode;
		logic word_full;
		logic last_word;
		logic bit_used;
		logic id_in_range;
		logic out_free;
	} sts_t;

endpackage

// File: rtl/bia_dp.sv
module bia_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [bia_pkg::ID_W-1:0]       s_tdata,
	input  logic                           s_tuser,
	input  bia_pkg::cmd_t                  cmd,
	output bia_pkg::sts_t                  sts,
	input  logic                           m_tready,
	output logic                           m_tvalid,
	output logic [bia_pkg::ID_W-1:0]       m_tdata,
	output logic [bia_pkg::STATUS_W-1:0]   m_tuser
);

	bia_pkg::word_t                 bitmap_q [bia_pkg::NUM_WORDS];
	logic                           mode_q;
	logic [bia_pkg::ID_W-1:0]       id_q;
	logic [bia_pkg::WIDX_W-1:0]     w_q;
	logic                           m_tvalid_q;
	logic [bia_pkg::ID_W-1:0]       m_gid_q;
	bia_pkg::status_t               m_status_q;

	logic [bia_pkg::ID_W-1:0]       free_word;
	logic [bia_pkg::BIT_W-1:0]      free_bit;
	logic [bia_pkg::WIDX_W-1:0]     rd_idx;
	bia_pkg::word_t                 rd_word;
	logic [bia_pkg::BIT_W-1:0]      first_zero;
	logic [bia_pkg::GID_W-1:0]      gid_full;

	assign free_word = bia_pkg::ID_W'(id_q / bia_pkg::WORD_BITS);
	assign free_bit  = bia_pkg::BIT_W'(id_q % bia_pkg::WORD_BITS);
	assign rd_idx    = (mode_q == bia_pkg::MODE_FREE) ? bia_pkg::WIDX_W'(free_word) : w_q;
	assign rd_word   = bitmap_q[rd_idx];

	// Lowest clear bit of the word under examination.
	always_comb begin
		first_zero = '0;
		for (int b = bia_pkg::WORD_BITS - 1; b >= 0; b--) begin
			if (!rd_word[b]) begin
				first_zero = bia_pkg::BIT_W'(b);
			end
		end
	end

	assign gid_full = bia_pkg::GID_W'(int'(w_q) * bia_pkg::WORD_BITS + int'(first_zero));

	assign sts.req_mode    = s_tuser;
	assign sts.word_full   = &rd_word;
	assign sts.last_word   = (w_q == bia_pkg::LAST_WORD);
	assign sts.bit_used    = rd_word[free_bit];
	assign sts.id_in_range = (int'(free_word) < bia_pkg::NUM_WORDS);
	assign sts.out_free    = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < bia_pkg::NUM_WORDS; w++) begin
				bitmap_q[w] <= '0;
			end
		end else begin
			if (cmd.set_bit) begin
				bitmap_q[w_q][first_zero] <= 1'b1;
			end
			if (cmd.clr_bit) begin
				bitmap_q[rd_idx][free_bit] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q        <= '0;
			mode_q     <= bia_pkg::MODE_ALLOC;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				w_q    <= '0;
				mode_q <= s_tuser;
			end else if (cmd.step) begin
				w_q <= w_q + 1'b1;
			end
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			id_q <= s_tdata;
		end
		if (cmd.out_load) begin
			m_gid_q    <= cmd.out_grant ? gid_full[bia_pkg::ID_W-1:0] : '0;
			m_status_q <= cmd.out_status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_gid_q;
	assign m_tuser  = m_status_q;

endmodule

// File: rtl/bia_ctrl.sv
module bia_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  bia_pkg::sts_t sts,
	output bia_pkg::cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_FREE = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = (sts.req_mode == bia_pkg::MODE_FREE) ? S_FREE : S_SCAN;
				end
			end
			S_SCAN: begin
				if (!sts.word_full) begin
					if (sts.out_free) begin
						cmd.set_bit    = 1'b1;
						cmd.out_load   = 1'b1;
						cmd.out_grant  = 1'b1;
						cmd.out_status = bia_pkg::STATUS_OK;
						state_d        = S_IDLE;
					end
				end else if (!sts.last_word) begin
					cmd.step = 1'b1;
				end else if (sts.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_status = bia_pkg::STATUS_FULL;
					state_d        = S_IDLE;
				end
			end
			S_FREE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.id_in_range && sts.bit_used) begin
						cmd.clr_bit    = 1'b1;
						cmd.out_status = bia_pkg::STATUS_OK;
					end else begin
						cmd.out_status = bia_pkg::STATUS_NOT_ALLOC;
					end
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/bitmap_id_allocator.sv
// Identifier allocator over a bitmap of NUM_WORDS words of WORD_BITS bits (256 identifiers
// as built). Each input beat is one request: tuser selects allocate (0) or free (1), and for
// a free request tdata names the identifier. Every request yields exactly one output beat
// carrying the granted identifier in tdata (zero for frees and failures) and a status code in
// tuser: ok, no free identifier, or freed identifier not allocated. Allocation returns the
// lowest free identifier; the words are examined one per clock from word 0, so an allocate
// beat scans from one to NUM_WORDS words before its result lands in the output register,
// and a free beat is decided in a single working state after acceptance; either one waits
// while the output register still holds an untaken result. The block handles one request
// at a time and accepts the next beat in the cycle after the previous result has been
// registered, even while that result still waits for the downstream side to take it. The
// bitmap lives in flip-flops that reset clears directly, so no clearing pass is needed and
// the block is ready straight after reset.
`include "bitmap_id_allocator_macros.svh"

module bitmap_id_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [bia_pkg::ID_W-1:0]       s_tdata,   // [7:0] id
	input  logic                           s_tuser,   // [0] mode
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [bia_pkg::ID_W-1:0]       m_tdata,   // [7:0] granted_id
	output logic [bia_pkg::STATUS_W-1:0]   m_tuser    // [1:0] status
);

	// Commands flow from the controller into the datapath; status flows back.
	bia_pkg::cmd_t cmd;
	bia_pkg::sts_t sts;

	// The controller sequences the word scan and decides when a result may be committed.
	bia_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the bitmap, the word counter, the lowest-zero search and the
	// output register.
	bia_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.sts      (sts),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// A bit may only be set in a word that has a free bit.
	`BIA_ASSERT_SAME(a_set_needs_free, cmd.set_bit, !sts.word_full, "set in a full word")
	// A result is never written over one that the downstream side has not yet taken.
	`BIA_ASSERT_SAME(a_no_overwrite, cmd.out_load, sts.out_free, "output beat overwritten")
	// Once a beat is taken, the block is busy in the following cycle.
	`BIA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready while busy")
	// Setting and clearing never happen in the same cycle.
	`BIA_ASSERT_SAME(a_set_clr_excl, cmd.set_bit, !cmd.clr_bit, "set and clear together")

endmodule
